### hw/rtl/atlas_shelf_packer_assert.svh
// Assertion macros shared by the shelf packer RTL.
`ifndef ATLAS_SHELF_PACKER_ASSERT_SVH
`define ATLAS_SHELF_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define ASP_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shelf packer: assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define ASP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shelf packer: assertion failed");
`else
`define ASP_ASSERT_IMPLIES(lbl, ante, cons)
`define ASP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/asp_pkg.sv
// Shared types, constants and helpers of the shelf packer.
package asp_pkg;

	localparam int SHEET_COUNT_LIMIT_DEF = 256;
	localparam int GLYPH_SIZE_LIMIT_DEF  = 1024;
	localparam int COORD_W               = 12;
	localparam int GLYPH_W               = 10;
	localparam int SHEET_OUT_W           = 8;
	localparam int QUEUE_DEPTH           = 4;
	localparam logic [COORD_W-1:0] LIMIT_RESET = 12'd2048;

	typedef logic [COORD_W-1:0]     coord_t;
	typedef logic [GLYPH_W-1:0]     glyph_t;
	typedef logic [SHEET_OUT_W-1:0] sheet_out_t;

	typedef enum logic {
		REG_WIDTH_LIMIT  = 1'b0,
		REG_HEIGHT_LIMIT = 1'b1
	} reg_index_t;

	typedef enum logic {
		KIND_PLACE = 1'b0,
		KIND_SHEET = 1'b1
	} kind_t;

	// One accepted item, fully classified: up to three records.
	typedef struct packed {
		logic       open_v;
		sheet_out_t open_sheet;
		coord_t     open_ex;
		coord_t     open_ey;
		sheet_out_t place_sheet;
		coord_t     place_x;
		coord_t     place_y;
		logic       close_v;
		coord_t     close_ex;
		coord_t     close_ey;
	} job_t;

	typedef struct packed {
		kind_t      kind;
		sheet_out_t sheet;
		coord_t     px;
		coord_t     py;
		coord_t     ex;
		coord_t     ey;
		logic       last;
	} rec_t;

	function automatic coord_t sat12(input logic [COORD_W:0] v);
		sat12 = v[COORD_W] ? {COORD_W{1'b1}} : v[COORD_W-1:0];
	endfunction

	function automatic coord_t max12(input coord_t a, input coord_t b);
		max12 = (a > b) ? a : b;
	endfunction

endpackage

### hw/rtl/asp_front.sv
// Front end: config registers, packing state and per-item classification.
module asp_front #(
	parameter int SHEET_COUNT_LIMIT = asp_pkg::SHEET_COUNT_LIMIT_DEF,
	parameter int GLYPH_SIZE_LIMIT  = asp_pkg::GLYPH_SIZE_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  asp_pkg::coord_t     cfg_data,
	input  logic                accept,
	input  asp_pkg::glyph_t     glyph_width,
	input  asp_pkg::glyph_t     glyph_height,
	input  logic                final_glyph,
	output logic                job_push,
	output asp_pkg::job_t       job
);

	localparam int SW = $clog2(SHEET_COUNT_LIMIT);
	localparam logic [SW-1:0] SHEET_MAX = SW'(SHEET_COUNT_LIMIT - 1);
	localparam int GMAX_INT = (GLYPH_SIZE_LIMIT - 1 > 1023) ? 1023 : GLYPH_SIZE_LIMIT - 1;
	localparam asp_pkg::glyph_t GLYPH_MAX = asp_pkg::GLYPH_W'(GMAX_INT);

	asp_pkg::coord_t width_limit_q, height_limit_q;
	asp_pkg::coord_t cursor_x_q, cursor_y_q, used_width_q, used_height_q;
	asp_pkg::glyph_t row_height_q;
	logic [SW-1:0]   sheet_q;

	asp_pkg::glyph_t w, h, rh_raise, rh_a;
	logic            new_row, new_sheet;
	logic [asp_pkg::COORD_W:0] row_sum, col_sum;
	asp_pkg::coord_t cx_a, cy_a, cy_row, cx_b, cy_b, uw_b, uh_b, cx_c, uw_c, top_c, uh_c;
	logic [SW-1:0]   sheet_b;
	logic [SW+7:0]   open_ext, place_ext;

	always_comb begin
		w = (glyph_width  > GLYPH_MAX) ? GLYPH_MAX : glyph_width;
		h = (glyph_height > GLYPH_MAX) ? GLYPH_MAX : glyph_height;
		rh_raise = (h > row_height_q) ? h : row_height_q;

		// row break
		row_sum = {1'b0, cursor_x_q} + 13'(w);
		new_row = row_sum >= {1'b0, width_limit_q};
		cy_row  = asp_pkg::sat12({1'b0, cursor_y_q} + 13'(rh_raise));
		cx_a    = new_row ? '0 : cursor_x_q;
		cy_a    = new_row ? cy_row : cursor_y_q;
		rh_a    = new_row ? h : rh_raise;

		// sheet break
		col_sum   = {1'b0, cy_a} + 13'(h);
		new_sheet = col_sum >= {1'b0, height_limit_q};
		sheet_b   = (new_sheet && sheet_q < SHEET_MAX) ? sheet_q + 1'b1 : sheet_q;
		cx_b      = new_sheet ? '0 : cx_a;
		cy_b      = new_sheet ? '0 : cy_a;
		uw_b      = new_sheet ? '0 : used_width_q;
		uh_b      = new_sheet ? '0 : used_height_q;

		// advance past the placed glyph
		cx_c  = asp_pkg::sat12({1'b0, cx_b} + 13'(w));
		uw_c  = asp_pkg::max12(uw_b, cx_c);
		top_c = asp_pkg::sat12({1'b0, cy_b} + 13'(rh_a));
		uh_c  = asp_pkg::max12(uh_b, top_c);

		open_ext  = {8'b0, sheet_q};
		place_ext = {8'b0, sheet_b};

		job.open_v      = new_sheet;
		job.open_sheet  = open_ext[7:0];
		job.open_ex     = used_width_q;
		job.open_ey     = used_height_q;
		job.place_sheet = place_ext[7:0];
		job.place_x     = cx_b;
		job.place_y     = cy_b;
		job.close_v     = final_glyph && (uw_c != '0) && (uh_c != '0);
		job.close_ex    = uw_c;
		job.close_ey    = uh_c;
	end

	assign job_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_limit_q  <= asp_pkg::LIMIT_RESET;
			height_limit_q <= asp_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (asp_pkg::reg_index_t'(cfg_index))
				asp_pkg::REG_WIDTH_LIMIT:  width_limit_q  <= cfg_data;
				asp_pkg::REG_HEIGHT_LIMIT: height_limit_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			row_height_q  <= '0;
			used_width_q  <= '0;
			used_height_q <= '0;
			sheet_q       <= '0;
		end else if (accept) begin
			if (final_glyph) begin
				cursor_x_q    <= '0;
				cursor_y_q    <= '0;
				row_height_q  <= '0;
				used_width_q  <= '0;
				used_height_q <= '0;
				sheet_q       <= '0;
			end else begin
				cursor_x_q    <= cx_c;
				cursor_y_q    <= cy_b;
				row_height_q  <= rh_a;
				used_width_q  <= uw_c;
				used_height_q <= uh_c;
				sheet_q       <= sheet_b;
			end
		end
	end

	`include "atlas_shelf_packer_assert.svh"

	`ASP_ASSERT_IMPLIES(a_sheet_bound, 1'b1, sheet_q <= SHEET_MAX)
	`ASP_ASSERT_NEXT(a_final_clears, accept && final_glyph, cursor_x_q == '0 && used_height_q == '0)

endmodule

### hw/rtl/asp_queue.sv
// Short job queue between front and back end.
module asp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  asp_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output asp_pkg::job_t rd_job
);

	localparam int DEPTH = asp_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	asp_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full     = cnt_q == (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`include "atlas_shelf_packer_assert.svh"

	`ASP_ASSERT_IMPLIES(a_no_overflow, push, !full || pop)
	`ASP_ASSERT_IMPLIES(a_no_underflow, pop, rd_valid)

endmodule

### hw/rtl/asp_back.sv
// Back end: unrolls queued jobs into records behind an output register.
module asp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  asp_pkg::job_t head_job,
	output logic          head_pop,
	output logic          empty,
	input  logic          pop,
	output asp_pkg::rec_t rec
);

	typedef enum logic [2:0] {
		PH_OPEN  = 3'b001,
		PH_PLACE = 3'b010,
		PH_CLOSE = 3'b100
	} phase_t;

	phase_t        phase_q;
	logic          out_v_q;
	asp_pkg::rec_t rec_q;

	logic          is_open, is_close, is_last, advance;
	asp_pkg::rec_t rec_d;

	always_comb begin
		is_open  = (phase_q == PH_OPEN) && head_job.open_v;
		is_close = phase_q == PH_CLOSE;
		is_last  = is_close || (!is_open && !head_job.close_v);
		advance  = head_valid && (!out_v_q || pop);

		rec_d.last = is_last;
		if (is_open) begin
			rec_d.kind  = asp_pkg::KIND_SHEET;
			rec_d.sheet = head_job.open_sheet;
			rec_d.px    = '0;
			rec_d.py    = '0;
			rec_d.ex    = head_job.open_ex;
			rec_d.ey    = head_job.open_ey;
		end else if (is_close) begin
			rec_d.kind  = asp_pkg::KIND_SHEET;
			rec_d.sheet = head_job.place_sheet;
			rec_d.px    = '0;
			rec_d.py    = '0;
			rec_d.ex    = head_job.close_ex;
			rec_d.ey    = head_job.close_ey;
		end else begin
			rec_d.kind  = asp_pkg::KIND_PLACE;
			rec_d.sheet = head_job.place_sheet;
			rec_d.px    = head_job.place_x;
			rec_d.py    = head_job.place_y;
			rec_d.ex    = '0;
			rec_d.ey    = '0;
		end
	end

	assign head_pop = advance && is_last;
	assign empty    = !out_v_q;
	assign rec      = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			out_v_q <= 1'b0;
		end else begin
			if (advance) begin
				out_v_q <= 1'b1;
				if (is_last)
					phase_q <= PH_OPEN;
				else if (is_open)
					phase_q <= PH_PLACE;
				else
					phase_q <= PH_CLOSE;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rec_q <= rec_d;
	end

	`include "atlas_shelf_packer_assert.svh"

	`ASP_ASSERT_IMPLIES(a_close_has_job, phase_q == PH_CLOSE, head_valid && head_job.close_v)
	`ASP_ASSERT_IMPLIES(a_place_no_extent, out_v_q && rec_q.kind == asp_pkg::KIND_PLACE,
		rec_q.ex == '0 && rec_q.ey == '0)

endmodule

### hw/rtl/atlas_shelf_packer.sv
// Top level of the shelf packer: front end, job queue and back end.
//
// Usage notes
// - Items in: glyph_width, glyph_height and final_glyph are taken at a rising
//   edge with push high and full low. One item per cycle is accepted as long
//   as the job queue has room.
// - Records out: while empty is low the oldest record sits on the result
//   ports; it is taken at an edge with pop high. Each item gives one to three
//   records (optional sheet close, placement, optional final sheet close);
//   last_of_run marks the last record of an item.
// - Flow: the edge that accepts an item writes its classified job into the
//   queue; the first record of the item is loaded into the output register
//   at a later edge, once that register is empty or being popped. The front
//   accepts one item a cycle; the back drains one record a cycle while pop
//   keeps up, so items that close sheets give it two or three records.
// - If pop stays low, the output register holds, the four-entry job queue
//   fills, and full rises; the packing state only moves on accepted items.
// - Config: cfg_we writes cfg_data to register cfg_index (0 width limit,
//   1 height limit) at once; write only while the block is idle.
// - Reset (arst_n low) clears the queue, the packing state and the sheet
//   count and sets both limits to 2048.
module atlas_shelf_packer #(
	parameter int SHEET_COUNT_LIMIT = asp_pkg::SHEET_COUNT_LIMIT_DEF,
	parameter int GLYPH_SIZE_LIMIT  = asp_pkg::GLYPH_SIZE_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  asp_pkg::coord_t        cfg_data,
	input  logic                   push,
	output logic                   full,
	input  asp_pkg::glyph_t        glyph_width,
	input  asp_pkg::glyph_t        glyph_height,
	input  logic                   final_glyph,
	output logic                   empty,
	input  logic                   pop,
	output logic                   record_kind,
	output asp_pkg::sheet_out_t    sheet_number,
	output asp_pkg::coord_t        place_x,
	output asp_pkg::coord_t        place_y,
	output asp_pkg::coord_t        sheet_extent_x,
	output asp_pkg::coord_t        sheet_extent_y,
	output logic                   last_of_run
);

	logic          accept;
	logic          job_push;
	asp_pkg::job_t job_in;
	logic          head_valid, head_pop;
	asp_pkg::job_t head_job;
	asp_pkg::rec_t rec;

	// an item enters only when the queue has a free slot
	assign accept = push && !full;

	asp_front #(
		.SHEET_COUNT_LIMIT (SHEET_COUNT_LIMIT),
		.GLYPH_SIZE_LIMIT  (GLYPH_SIZE_LIMIT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.glyph_width  (glyph_width),
		.glyph_height (glyph_height),
		.final_glyph  (final_glyph),
		.job_push     (job_push),
		.job          (job_in)
	);

	asp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.wr_job   (job_in),
		.full     (full),
		.pop      (head_pop),
		.rd_valid (head_valid),
		.rd_job   (head_job)
	);

	asp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.rec        (rec)
	);

	// record fields straight off the output register
	assign record_kind    = rec.kind;
	assign sheet_number   = rec.sheet;
	assign place_x        = rec.px;
	assign place_y        = rec.py;
	assign sheet_extent_x = rec.ex;
	assign sheet_extent_y = rec.ey;
	assign last_of_run    = rec.last;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the shelf packer: directed plan, random runs, checks per record.
module tb;

	localparam int COORD_TOP   = 4095;
	localparam int GLYPH_TOP   = asp_pkg::GLYPH_SIZE_LIMIT_DEF - 1;
	localparam int SHEET_TOP   = asp_pkg::SHEET_COUNT_LIMIT_DEF - 1;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic {
		ROW_GLYPH,
		ROW_LIMIT
	} row_op_t;

	// One row of the directed plan: an item, or a limit write done while idle.
	typedef struct {
		row_op_t             op;
		asp_pkg::glyph_t     w;
		asp_pkg::glyph_t     h;
		logic                fin;
		asp_pkg::reg_index_t idx;
		asp_pkg::coord_t     limit;
		logic                typed;	// rec holds the one record this item must give
		asp_pkg::rec_t       rec;
	} plan_row_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [0:0]          cfg_index    = 1'b0;
	asp_pkg::coord_t     cfg_data     = '0;
	logic                push         = 1'b0;
	logic                full;
	asp_pkg::glyph_t     glyph_width  = '0;
	asp_pkg::glyph_t     glyph_height = '0;
	logic                final_glyph  = 1'b0;
	logic                empty;
	logic                pop          = 1'b0;
	logic                record_kind;
	asp_pkg::sheet_out_t sheet_number;
	asp_pkg::coord_t     place_x;
	asp_pkg::coord_t     place_y;
	asp_pkg::coord_t     sheet_extent_x;
	asp_pkg::coord_t     sheet_extent_y;
	logic                last_of_run;

	// travels alongside the item so the monitor knows about typed rows
	logic          row_typed = 1'b0;
	asp_pkg::rec_t row_rec   = '0;

	atlas_shelf_packer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.glyph_width    (glyph_width),
		.glyph_height   (glyph_height),
		.final_glyph    (final_glyph),
		.empty          (empty),
		.pop            (pop),
		.record_kind    (record_kind),
		.sheet_number   (sheet_number),
		.place_x        (place_x),
		.place_y        (place_y),
		.sheet_extent_x (sheet_extent_x),
		.sheet_extent_y (sheet_extent_y),
		.last_of_run    (last_of_run)
	);

	always #1 clk = ~clk;

	// ---- packing predictor: own copy of limits and shelf state ----
	int width_limit  = int'(asp_pkg::LIMIT_RESET);
	int height_limit = int'(asp_pkg::LIMIT_RESET);
	int pen_x = 0, pen_y = 0, shelf_h = 0;
	int span_w = 0, span_h = 0, sheet_no = 0;

	asp_pkg::rec_t fresh_records[$];    // records of the item just accepted
	asp_pkg::rec_t awaited_records[$];  // records still owed by the block
	plan_row_t     plan[$];

	int mismatches  = 0;
	int cycle_count = 0;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_requests      = 0;

	function automatic void stash_record(asp_pkg::rec_t r);
		fresh_records.insert(fresh_records.size(), r);
	endfunction

	function automatic void owe_record(asp_pkg::rec_t r);
		awaited_records.insert(awaited_records.size(), r);
	endfunction

	function automatic void add_row(plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic int clip_coord(int v);
		return (v > COORD_TOP) ? COORD_TOP : v;
	endfunction

	function automatic void emit_record(asp_pkg::kind_t kind, int px, int py, int ex, int ey);
		asp_pkg::rec_t r;
		r.kind  = kind;
		r.sheet = asp_pkg::sheet_out_t'(sheet_no);
		r.px    = asp_pkg::coord_t'(px);
		r.py    = asp_pkg::coord_t'(py);
		r.ex    = asp_pkg::coord_t'(ex);
		r.ey    = asp_pkg::coord_t'(ey);
		r.last  = 1'b0;
		stash_record(r);
	endfunction

	function automatic void clear_shelves();
		pen_x    = 0;
		pen_y    = 0;
		shelf_h  = 0;
		span_w   = 0;
		span_h   = 0;
		sheet_no = 0;
	endfunction

	// Places one rectangle and fills fresh_records with what it gives.
	function automatic void pack_glyph(asp_pkg::glyph_t w_in, asp_pkg::glyph_t h_in, logic fin);
		int w;
		int h;
		w = (int'(w_in) > GLYPH_TOP) ? GLYPH_TOP : int'(w_in);
		h = (int'(h_in) > GLYPH_TOP) ? GLYPH_TOP : int'(h_in);
		fresh_records.delete();
		if (h > shelf_h)
			shelf_h = h;
		// shelf full: drop to a new shelf, whose height is this glyph's
		if (pen_x + w >= width_limit) begin
			pen_x   = 0;
			pen_y   = clip_coord(pen_y + shelf_h);
			shelf_h = h;
		end
		// sheet full: close it, even if nothing was placed on it
		if (pen_y + h >= height_limit) begin
			emit_record(asp_pkg::KIND_SHEET, 0, 0, span_w, span_h);
			if (sheet_no < SHEET_TOP)
				sheet_no++;
			span_w = 0;
			span_h = 0;
			pen_x  = 0;
			pen_y  = 0;
		end
		emit_record(asp_pkg::KIND_PLACE, pen_x, pen_y, 0, 0);
		pen_x = clip_coord(pen_x + w);
		if (pen_x > span_w)
			span_w = pen_x;
		if (clip_coord(pen_y + shelf_h) > span_h)
			span_h = clip_coord(pen_y + shelf_h);
		if (fin) begin
			if (span_w > 0 && span_h > 0)
				emit_record(asp_pkg::KIND_SHEET, 0, 0, span_w, span_h);
			clear_shelves();
		end
		fresh_records[fresh_records.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(string label, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			mismatches++;
		end
	endfunction

	// ---- monitor: predict on every accepted item, check every accepted record ----
	asp_pkg::rec_t due;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				pack_glyph(glyph_width, glyph_height, final_glyph);
				if (row_typed)
					owe_record(row_rec);
				else
					foreach (fresh_records[k])
						owe_record(fresh_records[k]);
			end
			if (pop && !empty) begin
				if (awaited_records.size() == 0) begin
					$display("%0t: record kind %0d sheet %0d with none awaited",
						$time, record_kind, sheet_number);
					mismatches++;
				end else begin
					due = awaited_records.pop_front();
					check_field("record_kind", int'(due.kind), int'(record_kind));
					check_field("sheet_number", int'(due.sheet), int'(sheet_number));
					check_field("place_x", int'(due.px), int'(place_x));
					check_field("place_y", int'(due.py), int'(place_y));
					check_field("sheet_extent_x", int'(due.ex), int'(sheet_extent_x));
					check_field("sheet_extent_y", int'(due.ey), int'(sheet_extent_y));
					check_field("last_of_run", int'(due.last), int'(last_of_run));
				end
			end
		end
	end

	// ---- receiver: random stalls, plus a long hold-off on request ----
	int hold_left   = 0;
	int hold_served = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timed out, %0d records still awaited", $time,
				awaited_records.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---- sender side ----
	function automatic plan_row_t glyph_row(int w, int h, logic fin);
		plan_row_t r;
		r.op    = ROW_GLYPH;
		r.w     = asp_pkg::glyph_t'(w);
		r.h     = asp_pkg::glyph_t'(h);
		r.fin   = fin;
		r.idx   = asp_pkg::REG_WIDTH_LIMIT;
		r.limit = '0;
		r.typed = 1'b0;
		r.rec   = '0;
		return r;
	endfunction

	// placement on sheet 0 that is the only record of its item
	function automatic plan_row_t typed_row(int w, int h, logic fin, int px, int py);
		plan_row_t r;
		r = glyph_row(w, h, fin);
		r.typed    = 1'b1;
		r.rec.kind = asp_pkg::KIND_PLACE;
		r.rec.px   = asp_pkg::coord_t'(px);
		r.rec.py   = asp_pkg::coord_t'(py);
		r.rec.last = 1'b1;
		return r;
	endfunction

	function automatic plan_row_t limit_row(asp_pkg::reg_index_t idx, int value);
		plan_row_t r;
		r = glyph_row(0, 0, 1'b0);
		r.op    = ROW_LIMIT;
		r.idx   = idx;
		r.limit = asp_pkg::coord_t'(value);
		return r;
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(0, 6))
			0:       return 0;
			1:       return 1;
			2:       return COORD_TOP;
			3:       return int'(asp_pkg::LIMIT_RESET);
			default: return $urandom_range(1, COORD_TOP);
		endcase
	endfunction

	// Offers one item, after a random idle gap, and returns at the edge that takes it.
	task automatic send_glyph(plan_row_t r);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		glyph_width  <= r.w;
		glyph_height <= r.h;
		final_glyph  <= r.fin;
		row_typed    <= r.typed;
		row_rec      <= r.rec;
		do
			@(posedge clk);
		while (full);
	endtask

	// Stops offering and waits for every owed record, plus the pipeline depth.
	task automatic settle();
		push <= 1'b0;
		@(negedge clk);
		wait (awaited_records.size() == 0);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(asp_pkg::reg_index_t idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= asp_pkg::coord_t'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == asp_pkg::REG_WIDTH_LIMIT)
			width_limit = value & 'hFFF;
		else
			height_limit = value & 'hFFF;
		@(posedge clk);
	endtask

	// Random runs of glyphs, most of them closed by a final item.
	task automatic send_runs(int count, int cap);
		int left;
		int run_len;
		logic fin;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(1, 10);
			for (int i = 0; i < run_len && left > 0; i++) begin
				fin = (i == run_len - 1) && ($urandom_range(0, 9) != 0);
				send_glyph(glyph_row($urandom_range(0, cap), $urandom_range(0, cap), fin));
				left--;
			end
		end
	endtask

	int idle_modes[4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{27, 27}};
	int glyph_caps[3] = '{GLYPH_TOP, 300, 40};

	initial begin
		// directed plan at reset limits: shelf wrap exactly at the limit,
		// sheet close, final flush, and finals with a zero extent
		add_row(typed_row(0, 0, 1'b0, 0, 0));
		add_row(typed_row(1023, 1023, 1'b0, 0, 0));
		add_row(typed_row(1023, 1, 1'b0, 1023, 0));
		add_row(typed_row(2, 1, 1'b0, 0, 1023));
		add_row(typed_row(5, 1023, 1'b0, 2, 1023));
		add_row(glyph_row(0, 2, 1'b0));
		add_row(glyph_row(1023, 1023, 1'b0));
		add_row(glyph_row(1023, 1023, 1'b0));
		add_row(glyph_row(1, 1, 1'b1));
		add_row(typed_row(0, 0, 1'b1, 0, 0));
		add_row(typed_row(5, 0, 1'b1, 0, 0));
		add_row(typed_row(0, 7, 1'b1, 0, 0));
		add_row(glyph_row(3, 4, 1'b1));
		// zero limits: every item wraps and closes a sheet, empty ones too
		add_row(limit_row(asp_pkg::REG_WIDTH_LIMIT, 0));
		add_row(limit_row(asp_pkg::REG_HEIGHT_LIMIT, 0));
		add_row(glyph_row(1, 1, 1'b0));
		add_row(glyph_row(0, 0, 1'b1));
		add_row(glyph_row(1, 1, 1'b1));
		add_row(glyph_row(1023, 1023, 1'b0));
		// limits at the top of the register range
		add_row(limit_row(asp_pkg::REG_WIDTH_LIMIT, COORD_TOP));
		add_row(limit_row(asp_pkg::REG_HEIGHT_LIMIT, COORD_TOP));
		add_row(glyph_row(1023, 1023, 1'b0));
		add_row(glyph_row(1023, 512, 1'b0));
		add_row(glyph_row(1023, 1023, 1'b0));
		add_row(glyph_row(1023, 1023, 1'b0));
		add_row(glyph_row(1023, 1023, 1'b1));
		// smallest legal limits
		add_row(limit_row(asp_pkg::REG_WIDTH_LIMIT, 1));
		add_row(limit_row(asp_pkg::REG_HEIGHT_LIMIT, 1));
		add_row(glyph_row(0, 0, 1'b0));
		add_row(glyph_row(1, 0, 1'b0));
		add_row(glyph_row(0, 1, 1'b1));
		add_row(limit_row(asp_pkg::REG_WIDTH_LIMIT, int'(asp_pkg::LIMIT_RESET)));
		add_row(limit_row(asp_pkg::REG_HEIGHT_LIMIT, int'(asp_pkg::LIMIT_RESET)));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == ROW_LIMIT) begin
				settle();
				set_limit(plan[i].idx, int'(plan[i].limit));
			end else begin
				send_glyph(plan[i]);
			end
		end

		// random runs under each idling mode, two limit settings per mode
		foreach (idle_modes[m]) begin
			for (int s = 0; s < 2; s++) begin
				settle();
				sender_idle_pct    = idle_modes[m][0];
				receiver_stall_pct = idle_modes[m][1];
				set_limit(asp_pkg::REG_WIDTH_LIMIT, pick_limit());
				set_limit(asp_pkg::REG_HEIGHT_LIMIT, pick_limit());
				send_runs(16, glyph_caps[$urandom_range(0, 2)]);
			end
		end

		// receiver holds off while items keep coming: queue fills, full rises
		settle();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		set_limit(asp_pkg::REG_WIDTH_LIMIT, 600);
		set_limit(asp_pkg::REG_HEIGHT_LIMIT, 900);
		hold_requests++;
		send_runs(20, 300);

		// height limit of zero closes a sheet per item, back to back
		settle();
		receiver_stall_pct = 27;
		set_limit(asp_pkg::REG_WIDTH_LIMIT, int'(asp_pkg::LIMIT_RESET));
		set_limit(asp_pkg::REG_HEIGHT_LIMIT, 0);
		for (int i = 0; i < 8; i++)
			send_glyph(glyph_row($urandom_range(0, 40), $urandom_range(0, 40), 1'b0));
		send_glyph(glyph_row($urandom_range(1, 40), $urandom_range(1, 40), 1'b1));

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_records.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
